/* hdl/pid_tolerance_damped_unit_defines.svh */
// assertion macros for the pid tolerance damped unit
`ifndef PID_TOLERANCE_DAMPED_UNIT_DEFINES_SVH
`define PID_TOLERANCE_DAMPED_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define PTD_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pid assertion failed");

// next-cycle implication checked outside reset
`define PTD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pid assertion failed");

`endif

/* hdl/ptd_pkg.sv */
// package: widths, band factors and helper functions of the pid unit
`timescale 1ns / 1ps
`default_nettype none
package ptd_pkg;
    localparam int GainWidth   = 24;
    localparam int LimitWidth  = 15;
    localparam int TolWidth    = 12;
    localparam int OutWidth    = 16;
    localparam int DefSampleWidth = 16;
    localparam int NumBands    = 6;
    // serial multiplier width: operands and product
    localparam int MulAWidth   = 24;
    localparam int MulBWidth   = 40;
    localparam int MulPWidth   = 64;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_KP   = 3'd0,
        REG_KI   = 3'd1,
        REG_KD   = 3'd2,
        REG_OLIM = 3'd3,
        REG_ILIM = 3'd4,
        REG_TOL  = 3'd5
    } reg_idx_t;

    // damping factors, Q0.8
    function automatic logic [7:0] band_factor(input logic [2:0] k);
        logic [7:0] f;
        begin
            case (k)
                3'd0: f = 8'd90;
                3'd1: f = 8'd115;
                3'd2: f = 8'd154;
                3'd3: f = 8'd192;
                3'd4: f = 8'd218;
                3'd5: f = 8'd243;
                default: f = 8'd0;
            endcase
            return f;
        end
    endfunction

    // multiplier request and response
    typedef struct packed {
        logic                 start;
        logic [MulAWidth-1:0] a;
        logic [MulBWidth-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                 done;
        logic [MulPWidth-1:0] prod;
    } mul_rsp_t;
endpackage
`default_nettype wire

/* hdl/ptd_serial_mul.sv */
// bit-serial shift-add multiplier, one multiplier bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ptd_serial_mul
    import ptd_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire mul_req_t req,
    output mul_rsp_t      rsp
);
    localparam int CntWidth = $clog2(MulAWidth + 1);

    logic [MulPWidth-1:0] acc_reg, acc_next;
    logic [MulPWidth-1:0] mcand_reg, mcand_next;
    logic [MulAWidth-1:0] mplier_reg, mplier_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    // shift-add step
    always_comb
    begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        cnt_next    = cnt_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (req.start)
        begin
            acc_next    = '0;
            mcand_next  = {{(MulPWidth-MulBWidth){1'b0}}, req.b};
            mplier_next = req.a;
            cnt_next    = CntWidth'(MulAWidth);
            busy_next   = 1'b1;
        end
        else if (busy_reg)
        begin
            if (mplier_reg[0])
                acc_next = acc_reg + mcand_reg;
            mcand_next  = mcand_reg << 1;
            mplier_next = mplier_reg >> 1;
            cnt_next    = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;
endmodule
`default_nettype wire

/* hdl/ptd_div10.sv */
// restoring divider by ten, one quotient bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module ptd_div10
    import ptd_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic [MulPWidth-1:0] dividend,
    output logic                      done,
    output logic [MulPWidth-1:0]      quotient
);
    localparam int CntWidth = $clog2(MulPWidth + 1);

    logic [MulPWidth-1:0] quo_reg, quo_next;
    logic [4:0]           rem_reg, rem_next;
    logic [CntWidth-1:0]  cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [4:0]           trial;

    // shift in one dividend bit, subtract ten where it fits
    always_comb
    begin
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = {rem_reg[3:0], quo_reg[MulPWidth-1]};
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = CntWidth'(MulPWidth);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= 5'd10)
            begin
                rem_next = trial - 5'd10;
                quo_next = {quo_reg[MulPWidth-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial;
                quo_next = {quo_reg[MulPWidth-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == CntWidth'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule
`default_nettype wire

/* hdl/pid_tolerance_damped_unit.sv */
// Top level of the pid unit with soft knee, band-damped derivative and clamps.
// One item at a time: a new item is accepted only after the previous result is taken.
// Each item takes four serial products, six when a damping band hits, and a divide by ten
// when the error magnitude is past the knee.
// Reset clears gains, limits, tolerance, previous error and integral to zero.
`timescale 1ns / 1ps
`default_nettype none
module pid_tolerance_damped_unit
    import ptd_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DefSampleWidth
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [2:0]            cfg_index,
    input  wire logic [GainWidth-1:0]  cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // target_value [15:0], feedback_value [31:16]
    input  wire logic [31:0]           s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // control_output [15:0]
    output logic [15:0]                m_tdata
);
    localparam int EW = SAMPLE_WIDTH + 1;
    localparam int DW = SAMPLE_WIDTH + 2;
    localparam int W  = 64;
    localparam int FW = 16;
    localparam int TW = (SAMPLE_WIDTH < FW) ? SAMPLE_WIDTH : FW;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_PK    = 11'b00000000010,
        ST_PE    = 11'b00000000100,
        ST_DIV   = 11'b00000001000,
        ST_IM    = 11'b00000010000,
        ST_DM    = 11'b00000100000,
        ST_DHI   = 11'b00001000000,
        ST_DLO   = 11'b00010000000,
        ST_SUM   = 11'b00100000000,
        ST_OUT   = 11'b01000000000,
        ST_ISS   = 11'b10000000000
    } state_t;

    state_t state_reg, state_next;

    logic [GainWidth-1:0]  kp_reg, ki_reg, kd_reg;
    logic [LimitWidth-1:0] olim_reg, ilim_reg;
    logic [TolWidth-1:0]   tol_reg;
    logic signed [EW-1:0]  prev_reg, e_reg;
    logic signed [W-1:0]   acc_reg;
    logic signed [DW-1:0]  dd_reg;
    logic [W-1:0]          pm_reg, t_reg, dmag_reg;
    logic [2:0]            band_reg;
    logic                  band_hit_reg;
    logic [15:0]           out_reg;
    logic                  out_valid_reg;

    mul_req_t mreq;
    mul_rsp_t mrsp;
    logic     div_start, div_done;
    logic [W-1:0] div_q;

    ptd_serial_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));
    ptd_div10 u_div (.clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(mrsp.prod), .done(div_done), .quotient(div_q));

    logic signed [SAMPLE_WIDTH-1:0] tgt, fbk;
    logic signed [EW-1:0] e_in;
    logic [EW-1:0]  em;
    logic [DW-1:0]  dm;
    logic [TolWidth+5:0] knee;
    logic [W-1:0]   prod;
    logic signed [W-1:0] iacc, ilim, sum, olim, pterm, dterm;
    logic           band_hit;
    logic [2:0]     band_sel;

    assign tgt  = SAMPLE_WIDTH'(s_tdata[TW-1:0]);
    assign fbk  = SAMPLE_WIDTH'(s_tdata[FW +: TW]);
    assign e_in = EW'(tgt) - EW'(fbk);
    assign em   = e_reg[EW-1] ? EW'(-e_reg) : EW'(e_reg);
    assign dm   = dd_reg[DW-1] ? DW'(-dd_reg) : DW'(dd_reg);
    assign knee = (TolWidth+6)'(tol_reg) * 6'd50;
    assign prod = mrsp.prod;
    assign ilim = W'({ilim_reg, 16'd0});
    assign olim = W'({olim_reg, 12'd0});
    assign pterm = e_reg[EW-1] ? -$signed(pm_reg) : $signed(pm_reg);
    assign dterm = dd_reg[DW-1] ? -$signed(dmag_reg) : $signed(dmag_reg);
    assign sum   = pterm + (acc_reg / 64'sd16) + dterm;
    assign iacc  = e_reg[EW-1] ? acc_reg - $signed(prod) : acc_reg + $signed(prod);

    // first damping band that holds the error change
    always_comb
    begin
        band_hit = 1'b0;
        band_sel = 3'd0;
        for (int k = NumBands - 1; k >= 0; k--)
            if (W'(dm) < (W'(tol_reg) << k))
            begin
                band_hit = 1'b1;
                band_sel = 3'(k);
            end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kp_reg <= '0; ki_reg <= '0; kd_reg <= '0;
            olim_reg <= '0; ilim_reg <= '0; tol_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_KP:   kp_reg   <= cfg_data;
                REG_KI:   ki_reg   <= cfg_data;
                REG_KD:   kd_reg   <= cfg_data;
                REG_OLIM: olim_reg <= cfg_data[LimitWidth-1:0];
                REG_ILIM: ilim_reg <= cfg_data[LimitWidth-1:0];
                REG_TOL:  tol_reg  <= cfg_data[TolWidth-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: multiplier requests and result steps
    always_comb
    begin
        state_next = state_reg;
        mreq       = '0;
        div_start  = 1'b0;
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready) state_next = ST_ISS;
            ST_ISS:
            begin
                // kp * knee first
                mreq.start = 1'b1;
                mreq.a = kp_reg;
                mreq.b = MulBWidth'(knee);
                state_next = ST_PK;
            end
            ST_PK: if (mrsp.done)
            begin
                mreq.start = 1'b1;
                mreq.a = kp_reg;
                mreq.b = (W'(em) > W'(knee)) ? MulBWidth'(W'(em) - W'(knee))
                                             : MulBWidth'(em);
                state_next = ST_PE;
            end
            ST_PE: if (mrsp.done)
            begin
                if (W'(em) > W'(knee))
                begin
                    div_start = 1'b1;
                    state_next = ST_DIV;
                end
                else
                begin
                    mreq.start = 1'b1;
                    mreq.a = ki_reg;
                    mreq.b = MulBWidth'({em, 4'd0});
                    state_next = ST_IM;
                end
            end
            ST_DIV: if (div_done)
            begin
                mreq.start = 1'b1;
                mreq.a = ki_reg;
                mreq.b = MulBWidth'({em, 4'd0});
                state_next = ST_IM;
            end
            ST_IM: if (mrsp.done)
            begin
                mreq.start = 1'b1;
                mreq.a = kd_reg;
                mreq.b = MulBWidth'(dm);
                state_next = ST_DM;
            end
            ST_DM: if (mrsp.done)
            begin
                if (band_hit_reg)
                begin
                    mreq.start = 1'b1;
                    mreq.a = MulAWidth'(band_factor(band_reg));
                    mreq.b = MulBWidth'(prod >> 8);
                    state_next = ST_DHI;
                end
                else
                    state_next = ST_SUM;
            end
            ST_DHI: if (mrsp.done)
            begin
                mreq.start = 1'b1;
                mreq.a = MulAWidth'(band_factor(band_reg));
                mreq.b = MulBWidth'(dmag_reg[7:0]);
                state_next = ST_DLO;
            end
            ST_DLO: if (mrsp.done) state_next = ST_SUM;
            ST_SUM: state_next = ST_OUT;
            ST_OUT: if (!out_valid_reg) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            prev_reg <= '0;
            acc_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_valid_reg && m_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                ST_IM: if (mrsp.done)
                begin
                    if (iacc > ilim) acc_reg <= ilim;
                    else if (iacc < -ilim) acc_reg <= -ilim;
                    else acc_reg <= iacc;
                end
                ST_SUM:
                begin
                    prev_reg <= e_reg;
                    out_valid_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE: if (s_tvalid && s_tready)
            begin
                e_reg  <= e_in;
                dd_reg <= DW'(e_in) - DW'(prev_reg);
            end
            ST_ISS:
            begin
                band_hit_reg <= band_hit;
                band_reg <= band_sel;
            end
            ST_PK: if (mrsp.done) t_reg <= prod;
            ST_PE: if (mrsp.done)
            begin
                if (W'(em) > W'(knee))
                begin
                    pm_reg <= t_reg;
                    t_reg <= prod;
                end
                else
                    pm_reg <= prod;
            end
            ST_DIV: if (div_done) pm_reg <= pm_reg + div_q;
            ST_DM: if (mrsp.done) dmag_reg <= prod;
            ST_DHI: if (mrsp.done) t_reg <= prod;
            ST_DLO: if (mrsp.done) dmag_reg <= t_reg + (prod >> 8);
            ST_SUM:
            begin
                if (sum > olim) out_reg <= 16'(olim / 64'sd4096);
                else if (sum < -olim) out_reg <= 16'((-olim) / 64'sd4096);
                else out_reg <= 16'(sum / 64'sd4096);
            end
            default: ;
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire

/* hdl/ptd_checker.sv */
// port-level checker for the pid unit and its bind
`timescale 1ns / 1ps
`default_nettype none
`include "pid_tolerance_damped_unit_defines.svh"
module ptd_checker
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic [15:0] m_tdata
);
    // one item in flight: no accept while a result waits
    `PTD_ASSERT_IMP(a_no_overlap, m_tvalid, !s_tready)
    // result never shows the most negative code
    `PTD_ASSERT_IMP(a_out_range, m_tvalid, m_tdata != 16'h8000)
    // no result right after an accept
    `PTD_ASSERT_NEXT(a_latency, s_tvalid && s_tready, !m_tvalid)
    // stalled result holds
    `PTD_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
endmodule

bind pid_tolerance_damped_unit ptd_checker u_ptd_checker (
    .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire

/* dv/tb_pid_tolerance_damped_unit.sv */
// testbench for the pid unit: streamed setpoint/feedback items checked against a predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_pid_tolerance_damped_unit;
    import ptd_pkg::*;

    localparam longint CycleLimit = 4000000;
    localparam int     DrainCycles = 400;
    localparam int     HoldCycles = 1500;

    // predictor of the drive output and queue of outputs still owed
    class pid_scoreboard;
        longint kp, ki, kd, olim, ilim, tol;
        longint last_err, integ;
        logic [15:0] drive_owed[$];
        int errors;
        int damp_q8[6];

        function new();
            kp = 0; ki = 0; kd = 0; olim = 0; ilim = 0; tol = 0;
            last_err = 0; integ = 0; errors = 0;
            damp_q8 = '{90, 115, 154, 192, 218, 243};
        endfunction

        function void set_reg(reg_idx_t idx, longint v);
            case (idx)
                REG_KP:   kp = v & 64'hFFFFFF;
                REG_KI:   ki = v & 64'hFFFFFF;
                REG_KD:   kd = v & 64'hFFFFFF;
                REG_OLIM: olim = v & 64'h7FFF;
                REG_ILIM: ilim = v & 64'h7FFF;
                REG_TOL:  tol = v & 64'hFFF;
                default:  ;
            endcase
        endfunction

        // work out the drive output for one accepted item
        function void note_item(logic [15:0] tgt, logic [15:0] fbk);
            longint e, em, knee, pm, p, acc, il, dd, dm, dmag, d, sum, ol;
            e = longint'($signed(tgt)) - longint'($signed(fbk));
            em = (e < 0) ? -e : e;
            // proportional with soft knee
            knee = tol * 50;
            if (em > knee)
                pm = kp * knee + (kp * (em - knee)) / 10;
            else
                pm = kp * em;
            p = (e < 0) ? -pm : pm;
            // integral with clamp
            acc = integ + ((e < 0) ? -(ki * em * 16) : ki * em * 16);
            il = ilim << 16;
            if (acc > il)
                acc = il;
            else if (acc < -il)
                acc = -il;
            integ = acc;
            // derivative, damped by the first band the change falls in
            dd = e - last_err;
            dm = (dd < 0) ? -dd : dd;
            dmag = kd * dm;
            for (int k = 0; k < 6; k++)
            begin
                if (dm < (tol << k))
                begin
                    dmag = (dmag >> 8) * damp_q8[k] + (((dmag & 255) * damp_q8[k]) >> 8);
                    break;
                end
            end
            d = (dd < 0) ? -dmag : dmag;
            // output clamp and truncation
            sum = p + acc / 16 + d;
            ol = olim << 12;
            if (sum > ol)
                sum = ol;
            else if (sum < -ol)
                sum = -ol;
            last_err = e;
            drive_owed.push_back(16'(sum / 4096));
        endfunction

        function void check_result(logic [15:0] act);
            logic [15:0] exp_val;
            if (drive_owed.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected item control_output=%0d", $time, $signed(act));
            end
            else
            begin
                exp_val = drive_owed.pop_front();
                if (exp_val !== act)
                begin
                    errors++;
                    $display("%0t: control_output expected %0d actual %0d",
                             $time, $signed(exp_val), $signed(act));
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;

    pid_scoreboard sb;
    longint cycles;
    int     results;
    logic   rx_started;

    pid_tolerance_damped_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("pid_tolerance_damped_unit: mismatch");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            sb.check_result(m_tdata);
            results <= results + 1;
        end
    end

    // receiver: stall pattern of its own, plus one long hold-off
    initial
    begin
        int mode_len;
        bit choppy;
        bit held;
        held = 0;
        m_tready = 1'b0;
        wait (rx_started);
        forever
        begin
            mode_len = $urandom_range(5, 300);
            choppy = $urandom_range(0, 1);
            repeat (mode_len)
            begin
                @(negedge clk);
                if (!held && results >= 400)
                begin
                    held = 1;
                    m_tready = 1'b0;
                    repeat (HoldCycles) @(negedge clk);
                end
                m_tready = choppy ? ($urandom_range(0, 3) != 0) : 1'b1;
            end
        end
    end

    // register write, done while the block is idle
    task automatic write_reg(reg_idx_t idx, logic [23:0] value);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(negedge clk);
        cfg_we = 1'b0;
        sb.set_reg(idx, value);
    endtask

    task automatic write_all(logic [23:0] kp, logic [23:0] ki, logic [23:0] kd,
                             logic [23:0] olim, logic [23:0] ilim, logic [23:0] tol);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_OLIM, olim);
        write_reg(REG_ILIM, ilim);
        write_reg(REG_TOL, tol);
    endtask

    // offer one item and hold it until accepted
    task automatic send_item(logic [15:0] tgt, logic [15:0] fbk);
        @(negedge clk);
        s_tvalid = 1'b1;
        s_tdata = {fbk, tgt};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_item(tgt, fbk);
    endtask

    task automatic pause_sender(int n);
        @(negedge clk);
        s_tvalid = 1'b0;
        repeat (n) @(negedge clk);
    endtask

    // wait for every owed output, then let the block settle
    task automatic drain();
        pause_sender(0);
        while (sb.drive_owed.size() != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    // random items in bursts; most errors sit below the knee, with changes around the damping bands
    task automatic random_items(int count);
        int burst;
        int sent;
        logic [15:0] tgt, fbk;
        int span;
        sent = 0;
        while (sent < count)
        begin
            burst = $urandom_range(1, 20);
            for (int i = 0; i < burst && sent < count; i++)
            begin
                tgt = 16'($urandom());
                if ($urandom_range(0, 3) == 0)
                    fbk = 16'($urandom());
                else
                begin
                    span = int'(sb.tol) * 64 + 8;
                    if (span > 65535)
                        span = 65535;
                    fbk = tgt - 16'($urandom_range(0, span)) + 16'(span / 2);
                end
                send_item(tgt, fbk);
                sent++;
            end
            if ($urandom_range(0, 2) != 0)
                pause_sender($urandom_range(1, 12));
        end
    endtask

    initial
    begin
        int errs[$];
        sb = new();
        cycles = 0;
        results = 0;
        rx_started = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_KP;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        rx_started = 1'b1;

        // directed: error steps through each damping band, knee and sample extremes
        write_all(24'd4096, 24'd41, 24'd2048, 24'd32767, 24'd1000, 24'd10);
        errs = '{0, 9, 28, 67, 146, 305, 624, 1264, 500, 501, -501, 0, 0};
        foreach (errs[i])
            send_item(16'(errs[i]), 16'd0);
        send_item(16'h7FFF, 16'h8000);
        send_item(16'h8000, 16'h7FFF);
        send_item(16'h7FFF, 16'h8000);
        send_item(16'h0000, 16'h0000);
        send_item(16'hFFFF, 16'h0001);
        drain();

        // random phases over several settings, extremes included
        random_items(430);
        drain();
        write_all(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'd32767, 24'd32767, 24'd4095);
        random_items(320);
        drain();
        write_all(24'd0, 24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        random_items(220);
        drain();
        write_all(24'd8192, 24'd200, 24'd40960, 24'd2000, 24'd300, 24'd0);
        random_items(320);
        drain();
        write_all(24'($urandom()), 24'($urandom_range(0, 4096)), 24'($urandom()),
                  24'($urandom_range(0, 32767)), 24'($urandom_range(0, 32767)),
                  24'($urandom_range(1, 64)));
        random_items(320);
        drain();
        write_all(24'($urandom_range(0, 65536)), 24'($urandom_range(0, 65536)),
                  24'($urandom_range(0, 65536)), 24'd32767, 24'd16, 24'd1);
        random_items(320);
        drain();

        if (sb.errors == 0 && sb.drive_owed.size() == 0)
            $display("pid_tolerance_damped_unit: match");
        else
            $display("pid_tolerance_damped_unit: mismatch");
        $finish;
    end
endmodule
`default_nettype wire
